/* hw/rtl/spcs_pkg.sv */
// Package for the servo and pulse code sender: command codes, register map,
// reset values and the structs passed between the core and its units.
// No dependencies.
`timescale 1ns / 1ps

package spcs_pkg;

    localparam int unsigned ValueWidth  = 16;
    localparam int unsigned CountWidth  = 5;
    localparam int unsigned NumChannels = 4;
    localparam int unsigned ChanWidth   = 2;
    localparam int unsigned AddrWidth   = 4;
    localparam int unsigned DataWidth   = 32;

    localparam logic [ValueWidth-1:0] PreambleReset = 16'd625;
    localparam logic [ValueWidth-1:0] OneReset      = 16'd317;
    localparam logic [ValueWidth-1:0] ShortReset    = 16'd80;
    localparam logic [CountWidth-1:0] BitCountReset = 5'd12;
    localparam logic [CountWidth-1:0] MaxBits       = 5'd16;

    // register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_PREAMBLE  = 2'd0,
        REG_ONE       = 2'd1,
        REG_SHORT     = 2'd2,
        REG_BIT_COUNT = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        CMD_TICK    = 3'd0,
        CMD_SET_ONE = 3'd1,
        CMD_OFF_ONE = 3'd2,
        CMD_SET_ALL = 3'd3,
        CMD_OFF_ALL = 3'd4,
        CMD_SEND    = 3'd5,
        CMD_MATCH   = 3'd6
    } cmd_t;

    typedef struct packed {
        logic [2:0]            cmd;
        logic [ChanWidth-1:0]  channel;
        logic [ValueWidth-1:0] value_a;
        logic [ValueWidth-1:0] value_b;
        logic [ValueWidth-1:0] value_c;
        logic [ValueWidth-1:0] value_d;
        logic [ValueWidth-1:0] code_word;
    } item_t;

    typedef struct packed {
        logic [ValueWidth-1:0] preamble_ticks;
        logic [ValueWidth-1:0] one_ticks;
        logic [ValueWidth-1:0] short_ticks;
        logic [CountWidth-1:0] bit_count;
    } cfg_t;

endpackage

/* hw/rtl/spcs_servo.sv */
// Servo compare bank: shadow and active values, enable and pending bits.
// Depends on spcs_pkg.
`timescale 1ns / 1ps

module spcs_servo
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step,
    input  spcs_pkg::item_t                  item,
    output logic [spcs_pkg::ValueWidth-1:0]  active_0,
    output logic [spcs_pkg::ValueWidth-1:0]  active_1,
    output logic [spcs_pkg::ValueWidth-1:0]  active_2,
    output logic [spcs_pkg::ValueWidth-1:0]  active_3,
    output logic [spcs_pkg::NumChannels-1:0] enable_mask,
    output logic [spcs_pkg::NumChannels-1:0] pending_mask
);

    logic [spcs_pkg::ValueWidth-1:0]  shadow_reg [spcs_pkg::NumChannels];
    logic [spcs_pkg::ValueWidth-1:0]  shadow_next [spcs_pkg::NumChannels];
    logic [spcs_pkg::ValueWidth-1:0]  active_reg [spcs_pkg::NumChannels];
    logic [spcs_pkg::ValueWidth-1:0]  active_next [spcs_pkg::NumChannels];
    logic [spcs_pkg::NumChannels-1:0] enable_reg, enable_next;
    logic [spcs_pkg::NumChannels-1:0] pending_reg, pending_next;
    logic [spcs_pkg::NumChannels-1:0] sel;

    assign sel = spcs_pkg::NumChannels'(1) << item.channel;

    always_comb
    begin
        shadow_next  = shadow_reg;
        active_next  = active_reg;
        enable_next  = enable_reg;
        pending_next = pending_reg;
        case (spcs_pkg::cmd_t'(item.cmd))
            spcs_pkg::CMD_SET_ONE:
            begin
                shadow_next[item.channel] = item.value_a;
                enable_next  = enable_reg | sel;
                pending_next = pending_reg | sel;
            end
            spcs_pkg::CMD_OFF_ONE:
            begin
                enable_next = enable_reg & ~sel;
            end
            spcs_pkg::CMD_SET_ALL:
            begin
                shadow_next[0] = item.value_a;
                shadow_next[1] = item.value_b;
                shadow_next[2] = item.value_c;
                shadow_next[3] = item.value_d;
                enable_next  = '1;
                pending_next = '1;
            end
            spcs_pkg::CMD_OFF_ALL:
            begin
                enable_next = '0;
            end
            spcs_pkg::CMD_MATCH:
            begin
                // a disabled comparator never matches
                if ((pending_reg & enable_reg & sel) != '0)
                begin
                    active_next[item.channel] = shadow_reg[item.channel];
                    pending_next = pending_reg & ~sel;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < spcs_pkg::NumChannels; i++)
            begin
                shadow_reg[i] <= '0;
                active_reg[i] <= '0;
            end
            enable_reg  <= '1;
            pending_reg <= '0;
        end
        else if (step)
        begin
            shadow_reg  <= shadow_next;
            active_reg  <= active_next;
            enable_reg  <= enable_next;
            pending_reg <= pending_next;
        end
    end

    assign active_0     = active_reg[0];
    assign active_1     = active_reg[1];
    assign active_2     = active_reg[2];
    assign active_3     = active_reg[3];
    assign enable_mask  = enable_reg;
    assign pending_mask = pending_reg;

endmodule

/* hw/rtl/spcs_sender.sv */
// Pulse-width code sender: preamble, bit high phases and low gaps, LSB first.
// Depends on spcs_pkg.
`timescale 1ns / 1ps

module spcs_sender
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  spcs_pkg::item_t item,
    input  spcs_pkg::cfg_t  cfg,
    output logic            line_level,
    output logic            sending
);

    logic [spcs_pkg::ValueWidth-1:0] code_reg, code_next;
    logic [spcs_pkg::ValueWidth-1:0] ticks_reg, ticks_next;
    logic [spcs_pkg::CountWidth-1:0] bits_reg, bits_next;
    logic                            low_reg, low_next;
    logic                            busy_reg, busy_next;
    logic                            line_reg, line_next;

    always_comb
    begin
        code_next  = code_reg;
        ticks_next = ticks_reg;
        bits_next  = bits_reg;
        low_next   = low_reg;
        busy_next  = busy_reg;
        line_next  = line_reg;
        case (spcs_pkg::cmd_t'(item.cmd))
            spcs_pkg::CMD_TICK:
            begin
                if (busy_reg)
                begin
                    if (ticks_reg != '0)
                    begin
                        ticks_next = ticks_reg - 1'b1;
                    end
                    else if (low_reg)
                    begin
                        low_next  = 1'b0;
                        line_next = 1'b1;
                        if (bits_reg != '0)
                        begin
                            bits_next  = bits_reg - 1'b1;
                            ticks_next = code_reg[0] ? cfg.one_ticks : cfg.short_ticks;
                            code_next  = code_reg >> 1;
                        end
                        else
                        begin
                            busy_next = 1'b0;
                        end
                    end
                    else
                    begin
                        low_next   = 1'b1;
                        ticks_next = cfg.short_ticks;
                        line_next  = 1'b0;
                    end
                end
            end
            spcs_pkg::CMD_SEND:
            begin
                // restarts from the preamble even mid-transfer
                code_next  = item.code_word;
                bits_next  = (cfg.bit_count > spcs_pkg::MaxBits) ? spcs_pkg::MaxBits
                                                                 : cfg.bit_count;
                ticks_next = cfg.preamble_ticks;
                low_next   = 1'b1;
                busy_next  = 1'b1;
                line_next  = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg  <= '0;
            ticks_reg <= '0;
            bits_reg  <= '0;
            low_reg   <= 1'b0;
            busy_reg  <= 1'b0;
            line_reg  <= 1'b1;
        end
        else if (step)
        begin
            code_reg  <= code_next;
            ticks_reg <= ticks_next;
            bits_reg  <= bits_next;
            low_reg   <= low_next;
            busy_reg  <= busy_next;
            line_reg  <= line_next;
        end
    end

    assign line_level = line_reg;
    assign sending    = busy_reg;

endmodule

/* hw/rtl/servo_and_pulse_code_sender_core.sv */
// Servo compare holder and pulse-width code sender, top level.
// Depends on spcs_pkg, spcs_servo and spcs_sender.
//
// Use:
//  - Input channel (in_valid/in_ready): one command per transfer. A tick
//    command advances the code timing; the others set or disable servo
//    channels, start a code, or signal a compare match.
//  - Output channel (out_valid/out_ready): exactly one result per command,
//    showing line level, sending flag, active values and the enable and
//    pending masks after that command.
//  - APB port: four timing registers at byte addresses 0, 4, 8 and 12; the
//    user must write them only while the block is idle, as the block does
//    not enforce it. pready is tied high.
// Throughput: one command per cycle while the receiver keeps out_ready high;
//   set by the single update step between the input register and the
//   state/result registers.
// Reset: servo values and pending bits clear, all channels enabled, line
//   high and sender idle; registers return to their default timings.
// Stall: while the receiver holds out_ready low the result is held; one more
//   command waits in the input register, then in_ready drops.
`timescale 1ns / 1ps

module servo_and_pulse_code_sender_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    // command channel
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [2:0]                       cmd,
    input  logic [spcs_pkg::ChanWidth-1:0]   channel,
    input  logic [spcs_pkg::ValueWidth-1:0]  value_a,
    input  logic [spcs_pkg::ValueWidth-1:0]  value_b,
    input  logic [spcs_pkg::ValueWidth-1:0]  value_c,
    input  logic [spcs_pkg::ValueWidth-1:0]  value_d,
    input  logic [spcs_pkg::ValueWidth-1:0]  code_word,
    // result channel
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             line_level,
    output logic                             sending,
    output logic [spcs_pkg::ValueWidth-1:0]  active_0,
    output logic [spcs_pkg::ValueWidth-1:0]  active_1,
    output logic [spcs_pkg::ValueWidth-1:0]  active_2,
    output logic [spcs_pkg::ValueWidth-1:0]  active_3,
    output logic [spcs_pkg::NumChannels-1:0] enable_mask,
    output logic [spcs_pkg::NumChannels-1:0] pending_mask,
    // APB configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [spcs_pkg::AddrWidth-1:0]   paddr,
    input  logic [spcs_pkg::DataWidth-1:0]   pwdata,
    output logic [spcs_pkg::DataWidth-1:0]   prdata,
    output logic                             pready
);

    // configuration registers
    spcs_pkg::cfg_t cfg_reg;
    logic           cfg_wr;
    spcs_pkg::reg_idx_t reg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = spcs_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.preamble_ticks <= spcs_pkg::PreambleReset;
            cfg_reg.one_ticks      <= spcs_pkg::OneReset;
            cfg_reg.short_ticks    <= spcs_pkg::ShortReset;
            cfg_reg.bit_count      <= spcs_pkg::BitCountReset;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                spcs_pkg::REG_PREAMBLE:  cfg_reg.preamble_ticks <= pwdata[15:0];
                spcs_pkg::REG_ONE:       cfg_reg.one_ticks      <= pwdata[15:0];
                spcs_pkg::REG_SHORT:     cfg_reg.short_ticks    <= pwdata[15:0];
                spcs_pkg::REG_BIT_COUNT: cfg_reg.bit_count      <= pwdata[4:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            spcs_pkg::REG_PREAMBLE:  prdata = {16'd0, cfg_reg.preamble_ticks};
            spcs_pkg::REG_ONE:       prdata = {16'd0, cfg_reg.one_ticks};
            spcs_pkg::REG_SHORT:     prdata = {16'd0, cfg_reg.short_ticks};
            spcs_pkg::REG_BIT_COUNT: prdata = {27'd0, cfg_reg.bit_count};
            default:                 prdata = '0;
        endcase
    end

    // input register; the state registers in the units double as the result
    // register, as they only change when a result is loaded
    logic            in_valid_reg;
    spcs_pkg::item_t item_reg;
    logic            out_valid_reg, out_valid_next;
    logic            out_free;
    logic            advance;

    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || out_free;

    always_comb
    begin
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.cmd       <= cmd;
            item_reg.channel   <= channel;
            item_reg.value_a   <= value_a;
            item_reg.value_b   <= value_b;
            item_reg.value_c   <= value_c;
            item_reg.value_d   <= value_d;
            item_reg.code_word <= code_word;
        end
    end

    assign out_valid = out_valid_reg;

    spcs_servo u_servo
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .item         (item_reg),
        .active_0     (active_0),
        .active_1     (active_1),
        .active_2     (active_2),
        .active_3     (active_3),
        .enable_mask  (enable_mask),
        .pending_mask (pending_mask)
    );

    spcs_sender u_sender
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .item       (item_reg),
        .cfg        (cfg_reg),
        .line_level (line_level),
        .sending    (sending)
    );

endmodule

/* tb/spcs_result_checker.sv */
// Result checker for the servo and pulse code sender: watches both channels and the
// APB port, predicts each result from its own copy of the state, and compares.
// Depends on spcs_pkg.
`timescale 1ns / 1ps

module spcs_result_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic [2:0]                       cmd,
    input  logic [spcs_pkg::ChanWidth-1:0]   channel,
    input  logic [spcs_pkg::ValueWidth-1:0]  value_a,
    input  logic [spcs_pkg::ValueWidth-1:0]  value_b,
    input  logic [spcs_pkg::ValueWidth-1:0]  value_c,
    input  logic [spcs_pkg::ValueWidth-1:0]  value_d,
    input  logic [spcs_pkg::ValueWidth-1:0]  code_word,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic                             line_level,
    input  logic                             sending,
    input  logic [spcs_pkg::ValueWidth-1:0]  active_0,
    input  logic [spcs_pkg::ValueWidth-1:0]  active_1,
    input  logic [spcs_pkg::ValueWidth-1:0]  active_2,
    input  logic [spcs_pkg::ValueWidth-1:0]  active_3,
    input  logic [spcs_pkg::NumChannels-1:0] enable_mask,
    input  logic [spcs_pkg::NumChannels-1:0] pending_mask,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic                             pready,
    input  logic [spcs_pkg::AddrWidth-1:0]   paddr,
    input  logic [spcs_pkg::DataWidth-1:0]   pwdata,
    output int                               fail_count,
    output int                               results_due
);

    import spcs_pkg::*;

    typedef struct packed {
        logic                   line;
        logic                   busy;
        logic [ValueWidth-1:0]  act0;
        logic [ValueWidth-1:0]  act1;
        logic [ValueWidth-1:0]  act2;
        logic [ValueWidth-1:0]  act3;
        logic [NumChannels-1:0] en;
        logic [NumChannels-1:0] pend;
    } status_t;

    // predictor state
    cfg_t                   timing;
    logic [ValueWidth-1:0]  shadow_val [NumChannels];
    logic [ValueWidth-1:0]  active_val [NumChannels];
    logic [NumChannels-1:0] en_bits;
    logic [NumChannels-1:0] pend_bits;
    logic [ValueWidth-1:0]  code_bits;
    logic [ValueWidth-1:0]  phase_ticks;
    logic [CountWidth-1:0]  bits_to_go;
    logic                   gap_phase;
    logic                   tx_busy;
    logic                   line_hi;

    status_t status_due [$];
    int      errors = 0;
    int      result_no = 0;

    initial fail_count = 0;
    initial results_due = 0;

    task automatic compare_field(input string name, input int unsigned want_v,
                                 input int unsigned got_v);
        if (want_v != got_v)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch in result %0d, %s: expected %h, got %h",
                         result_no, name, want_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : predict_and_compare
        status_t             want;
        status_t             got;
        logic [NumChannels-1:0] sel;
        int                  i;

        if (!rst_n)
        begin
            timing      = '{PreambleReset, OneReset, ShortReset, BitCountReset};
            for (i = 0; i < NumChannels; i++)
            begin
                shadow_val[i] = '0;
                active_val[i] = '0;
            end
            en_bits     = '1;
            pend_bits   = '0;
            code_bits   = '0;
            phase_ticks = '0;
            bits_to_go  = '0;
            gap_phase   = 1'b0;
            tx_busy     = 1'b0;
            line_hi     = 1'b1;
            status_due.delete();
        end
        else
        begin
            // result side first: nothing accepted at this edge can already be out
            if (out_valid && out_ready)
            begin
                got = '{line_level, sending, active_0, active_1, active_2, active_3,
                        enable_mask, pending_mask};
                if (status_due.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("result %0d arrived with nothing expected", result_no);
                end
                else
                begin
                    want = status_due.pop_front();
                    compare_field("line_level",   want.line, got.line);
                    compare_field("sending",      want.busy, got.busy);
                    compare_field("active_0",     want.act0, got.act0);
                    compare_field("active_1",     want.act1, got.act1);
                    compare_field("active_2",     want.act2, got.act2);
                    compare_field("active_3",     want.act3, got.act3);
                    compare_field("enable_mask",  want.en,   got.en);
                    compare_field("pending_mask", want.pend, got.pend);
                end
                result_no++;
            end

            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_PREAMBLE:  timing.preamble_ticks = pwdata[ValueWidth-1:0];
                    REG_ONE:       timing.one_ticks      = pwdata[ValueWidth-1:0];
                    REG_SHORT:     timing.short_ticks    = pwdata[ValueWidth-1:0];
                    REG_BIT_COUNT: timing.bit_count      = pwdata[CountWidth-1:0];
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                sel = NumChannels'(1) << channel;
                case (cmd)
                    CMD_TICK:
                    begin
                        if (tx_busy)
                        begin
                            if (phase_ticks != '0)
                                phase_ticks = phase_ticks - 1'b1;
                            else if (gap_phase)
                            begin
                                // low phase over: next bit's high phase, or idle
                                gap_phase = 1'b0;
                                line_hi   = 1'b1;
                                if (bits_to_go != '0)
                                begin
                                    bits_to_go  = bits_to_go - 1'b1;
                                    phase_ticks = code_bits[0] ? timing.one_ticks
                                                               : timing.short_ticks;
                                    code_bits   = code_bits >> 1;
                                end
                                else
                                    tx_busy = 1'b0;
                            end
                            else
                            begin
                                gap_phase   = 1'b1;
                                phase_ticks = timing.short_ticks;
                                line_hi     = 1'b0;
                            end
                        end
                    end
                    CMD_SET_ONE:
                    begin
                        shadow_val[channel] = value_a;
                        en_bits   = en_bits | sel;
                        pend_bits = pend_bits | sel;
                    end
                    CMD_OFF_ONE: en_bits = en_bits & ~sel;
                    CMD_SET_ALL:
                    begin
                        shadow_val[0] = value_a;
                        shadow_val[1] = value_b;
                        shadow_val[2] = value_c;
                        shadow_val[3] = value_d;
                        en_bits   = '1;
                        pend_bits = '1;
                    end
                    CMD_OFF_ALL: en_bits = '0;
                    CMD_SEND:
                    begin
                        code_bits   = code_word;
                        bits_to_go  = (timing.bit_count > MaxBits) ? MaxBits
                                                                   : timing.bit_count;
                        phase_ticks = timing.preamble_ticks;
                        gap_phase   = 1'b1;
                        tx_busy     = 1'b1;
                        line_hi     = 1'b0;
                    end
                    CMD_MATCH:
                    begin
                        if ((pend_bits & sel) != '0 && (en_bits & sel) != '0)
                        begin
                            active_val[channel] = shadow_val[channel];
                            pend_bits = pend_bits & ~sel;
                        end
                    end
                    default: ;
                endcase
                status_due.push_back('{line_hi, tx_busy, active_val[0], active_val[1],
                                       active_val[2], active_val[3], en_bits, pend_bits});
            end
        end
        fail_count  <= errors;
        results_due <= status_due.size();
    end

endmodule

/* tb/servo_and_pulse_code_sender_core_tb.sv */
// Testbench top for the servo and pulse code sender core: drives commands, the
// result back-pressure and the APB timing registers, and gives the verdict.
// Depends on spcs_pkg, servo_and_pulse_code_sender_core and spcs_result_checker.
`timescale 1ns / 1ps

module servo_and_pulse_code_sender_core_tb;

    import spcs_pkg::*;

    // no member of cmd_t covers the spare encoding; the block must ignore it
    localparam logic [2:0] CmdSpare = 3'd7;
    // length of the forced receiver hold-off, long enough to back the block up
    localparam int LongHold = 60;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;

    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [2:0]             cmd = '0;
    logic [ChanWidth-1:0]   channel = '0;
    logic [ValueWidth-1:0]  value_a = '0;
    logic [ValueWidth-1:0]  value_b = '0;
    logic [ValueWidth-1:0]  value_c = '0;
    logic [ValueWidth-1:0]  value_d = '0;
    logic [ValueWidth-1:0]  code_word = '0;

    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   line_level;
    logic                   sending;
    logic [ValueWidth-1:0]  active_0;
    logic [ValueWidth-1:0]  active_1;
    logic [ValueWidth-1:0]  active_2;
    logic [ValueWidth-1:0]  active_3;
    logic [NumChannels-1:0] enable_mask;
    logic [NumChannels-1:0] pending_mask;

    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [AddrWidth-1:0]   paddr = '0;
    logic [DataWidth-1:0]   pwdata = '0;
    logic [DataWidth-1:0]   prdata;
    logic                   pready;

    int                     fail_count;
    int                     results_due;

    // idling percentages: gap_pct belongs to the command side (this module's
    // stimulus process), stall_pct is read by the receiver process
    int                     gap_pct = 0;
    int                     stall_pct = 0;

    // each toggle of hold_trigger asks the receiver for one long hold-off
    logic                   hold_trigger = 1'b0;
    logic                   hold_seen = 1'b0;
    int                     hold_left = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    servo_and_pulse_code_sender_core uut (.*);

    spcs_result_checker checker_i (.*);

    // Result side: random stalls at stall_pct, or a counted hold-off when asked.
    // Everything is driven with NBAs at the rising edge so the block samples
    // settled values.
    always @(posedge clk)
    begin
        if (hold_trigger != hold_seen)
        begin
            hold_seen <= hold_trigger;
            hold_left <= LongHold;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Watchdog: far beyond the slowest correct run, even with every stall and
    // gap at its worst.
    initial
    begin
        #5_000_000;
        $display("[servo_and_pulse_code_sender_core] ERROR");
        $finish;
    end

    task automatic set_idling(input int gap, input int stall);
        gap_pct   = gap;
        stall_pct <= stall;
    endtask

    // One command transfer. An optional gap comes first, with valid low; once
    // valid rises it stays up with a fixed payload until in_ready is seen at an
    // edge. Returns at the edge of the transfer, valid still high.
    task automatic drive_item(input logic [2:0] c, input logic [ChanWidth-1:0] ch,
                              input logic [ValueWidth-1:0] va,
                              input logic [ValueWidth-1:0] vb,
                              input logic [ValueWidth-1:0] vc,
                              input logic [ValueWidth-1:0] vd,
                              input logic [ValueWidth-1:0] code);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= c;
        channel   <= ch;
        value_a   <= va;
        value_b   <= vb;
        value_c   <= vc;
        value_d   <= vd;
        code_word <= code;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Command with every other field random, so each bit sees both values.
    task automatic random_fields(input logic [2:0] c);
        drive_item(c, ChanWidth'($urandom_range(0, 3)),
                   ValueWidth'($urandom_range(0, 65535)),
                   ValueWidth'($urandom_range(0, 65535)),
                   ValueWidth'($urandom_range(0, 65535)),
                   ValueWidth'($urandom_range(0, 65535)),
                   ValueWidth'($urandom_range(0, 65535)));
    endtask

    // Stop offering and wait until every predicted result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
    endtask

    // APB write: setup, access (write edge), then an idle phase, so the next
    // write's setup never lands in the same step as this one's release.
    task automatic reg_write(input reg_idx_t idx, input logic [DataWidth-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // New timings, only with the block idle: drain, let the input and state
    // registers settle, then write all four registers.
    task automatic configure(input logic [ValueWidth-1:0] pre,
                             input logic [ValueWidth-1:0] one,
                             input logic [ValueWidth-1:0] shrt,
                             input logic [CountWidth-1:0] nbits);
        drain();
        repeat (4) @(posedge clk);
        reg_write(REG_PREAMBLE,  DataWidth'(pre));
        reg_write(REG_ONE,       DataWidth'(one));
        reg_write(REG_SHORT,     DataWidth'(shrt));
        reg_write(REG_BIT_COUNT, DataWidth'(nbits));
    endtask

    // Random traffic. Ticks dominate and often come in bursts right after a
    // send, so codes actually run through preamble, bits and gaps; sets are
    // frequent enough that matches usually find something pending.
    task automatic random_items(input int count);
        int done;
        int pick;
        int burst;
        done = 0;
        while (done < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                burst = $urandom_range(10, 50);
                repeat (burst) random_fields(CMD_TICK);
                done += burst;
            end
            else if (pick < 45)
            begin
                random_fields(CMD_TICK);
                done++;
            end
            else if (pick < 50)
            begin
                random_fields(CMD_SEND);
                done++;
                if ($urandom_range(0, 1) == 1)
                begin
                    burst = $urandom_range(20, 70);
                    repeat (burst) random_fields(CMD_TICK);
                    done += burst;
                end
            end
            else if (pick < 62)
            begin
                random_fields(CMD_SET_ONE);
                done++;
            end
            else if (pick < 67)
            begin
                random_fields(CMD_OFF_ONE);
                done++;
            end
            else if (pick < 72)
            begin
                random_fields(CMD_SET_ALL);
                done++;
            end
            else if (pick < 74)
            begin
                random_fields(CMD_OFF_ALL);
                done++;
            end
            else if (pick < 96)
            begin
                random_fields(CMD_MATCH);
                done++;
            end
            else
            begin
                random_fields(CmdSpare);
                done++;
            end
        end
    endtask

    initial
    begin : stimulus
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        set_idling(10, 49);
        @(posedge clk);

        // Directed part, at the reset timings
        // tick with nothing to send, match with nothing pending
        drive_item(CMD_TICK,    2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        drive_item(CMD_MATCH,   2'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // single-channel sets at the value extremes, then their matches
        drive_item(CMD_SET_ONE, 2'd0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        drive_item(CMD_SET_ONE, 2'd3, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        drive_item(CMD_MATCH,   2'd3, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        drive_item(CMD_MATCH,   2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        // match only loads the named channel; a second match is a no-op
        drive_item(CMD_SET_ALL, 2'd2, 16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555, 16'h1234);
        drive_item(CMD_MATCH,   2'd2, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        drive_item(CMD_MATCH,   2'd2, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        // disabled comparator ignores its match but keeps the pending bit
        drive_item(CMD_OFF_ONE, 2'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        drive_item(CMD_MATCH,   2'd1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        drive_item(CMD_OFF_ALL, 2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        drive_item(CMD_MATCH,   2'd3, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        // a set re-enables the channel
        drive_item(CMD_SET_ONE, 2'd1, 16'h8001, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        drive_item(CMD_MATCH,   2'd1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        // spare command code: ignored, result still returned
        drive_item(CmdSpare,    2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // send, a few ticks, then a restart while busy
        drive_item(CMD_SEND,    2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
        drive_item(CMD_TICK,    2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        drive_item(CMD_TICK,    2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        drive_item(CMD_SEND,    2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        // servo commands while sending leave the code timing alone
        drive_item(CMD_SET_ALL, 2'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
        drive_item(CMD_MATCH,   2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        drive_item(CMD_TICK,    2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);

        // Short timings: whole codes fit in the tick bursts
        configure(16'd2, 16'd3, 16'd1, 5'd4);
        random_items(240);
        // receiver holds off while commands keep coming, so the block backs up
        hold_trigger <= ~hold_trigger;
        random_items(80);
        // sender pauses until every result is back, then carries on
        drain();
        random_items(40);

        // lowest timings, and a bit count of zero: preamble only
        configure(16'd0, 16'd0, 16'd0, 5'd0);
        random_items(150);

        set_idling(49, 10);
        // highest timings; bit count beyond sixteen saturates
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31);
        random_items(120);

        configure(16'd0, 16'd0, 16'd0, 5'd16);
        random_items(150);
        hold_trigger <= ~hold_trigger;
        random_items(100);

        set_idling(0, 0);
        configure(16'd1, 16'd2, 16'd0, 5'd17);
        random_items(250);
        configure(16'd3, 16'd1, 16'd2, 5'd1);
        random_items(200);

        // all offered; let the results drain and give a stray one time to show
        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && results_due == 0)
            $display("[servo_and_pulse_code_sender_core] OK");
        else
            $display("[servo_and_pulse_code_sender_core] ERROR");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/spcs_pkg.sv
hw/rtl/spcs_servo.sv
hw/rtl/spcs_sender.sv
hw/rtl/servo_and_pulse_code_sender_core.sv
tb/spcs_result_checker.sv
tb/servo_and_pulse_code_sender_core_tb.sv
